// ----- rtl/ffd_pkg.sv -----
`timescale 1ns / 1ps

package ffd_pkg;

   // Fixed widths of the item fields
   localparam int MAG_W    = 32;
   localparam int FLEN_W   = 5;
   localparam int PREC_W   = 4;
   localparam int CHAR_W   = 8;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int DIGIT_W  = 4;

   // Decimal digits needed to hold any magnitude
   localparam int MAG_DIGITS = 10;

   // Default longest field
   localparam int MAX_LENGTH_DEFAULT = 16;

   // Characters
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LENGTH = 2'd2;

   typedef struct packed {
      logic [MAG_W-1:0]  magnitude;
      logic              negative;
      logic [FLEN_W-1:0] field_length;
      logic [PREC_W-1:0] decimal_places;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   character;
      logic [POS_W-1:0]    position;
      logic                last;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Control shared by every digit cell
   typedef struct packed {
      logic clear;
      logic dabble;
      logic shift;
   } cell_ctl_type;

endpackage

// ----- rtl/ffd_cell.sv -----
`timescale 1ns / 1ps

module ffd_cell (
   input  logic                       clock,
   input  ffd_pkg::cell_ctl_type      ctl,
   input  logic                       low_bit,
   input  logic [ffd_pkg::DIGIT_W-1:0] low_digit,
   output logic                       carry_out,
   output logic [ffd_pkg::DIGIT_W-1:0] digit_out
);

   logic [ffd_pkg::DIGIT_W-1:0] digit_ff;
   logic [ffd_pkg::DIGIT_W-1:0] digit_in;
   logic [ffd_pkg::DIGIT_W-1:0] adj;

   // add-3 correction before the doubling shift
   always_comb begin
      adj = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   end

   assign carry_out = adj[3];
   assign digit_out = digit_ff;

   always_comb begin
      priority if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.dabble) begin
         digit_in = {adj[2:0], low_bit};
      end else if (ctl.shift) begin
         digit_in = low_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

// ----- rtl/ffd_chain.sv -----
`timescale 1ns / 1ps

module ffd_chain #(
   parameter int NCELL = ffd_pkg::MAG_DIGITS
) (
   input  logic                        clock,
   input  ffd_pkg::cell_ctl_type       ctl,
   input  logic                        mag_bit,
   output logic [ffd_pkg::DIGIT_W-1:0] top_digit,
   output logic [ffd_pkg::DIGIT_W-1:0] next_digit
);

   logic [ffd_pkg::DIGIT_W-1:0] digit [NCELL];
   logic                        carry [NCELL];

   // cell 0 is the least significant digit; bits and digits move upward
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      if (i == 0) begin : g_first
         ffd_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .low_bit   (mag_bit),
            .low_digit ('0),
            .carry_out (carry[i]),
            .digit_out (digit[i])
         );
      end else begin : g_rest
         ffd_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .low_bit   (carry[i-1]),
            .low_digit (digit[i-1]),
            .carry_out (carry[i]),
            .digit_out (digit[i])
         );
      end
   end

   assign top_digit  = digit[NCELL-1];
   assign next_digit = digit[NCELL-2];

endmodule

// ----- rtl/fixed_field_decimal_formatter_core.sv -----
`timescale 1ns / 1ps
// Flow: an item is taken in idle, converted in the digit cells, aligned by shifting off
// the digits above the field, then emitted from the top cell through the output register;
// a field with status 2 goes from the idle state straight to emit and the output register.
// Emit gives one character per cycle while the output is not stalled; the input stalls
// from taking an item until its last character is emitted. NCELL is 15 by default.
// Reset: synchronous, active high; clears the sequencer and output valid, not the cells.

module fixed_field_decimal_formatter_core #(
   parameter int MAX_LENGTH = ffd_pkg::MAX_LENGTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ffd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ffd_pkg::rsp_type rsp_payload
);

   localparam int NCELL  = (MAX_LENGTH - 1 > ffd_pkg::MAG_DIGITS) ?
                           MAX_LENGTH - 1 : ffd_pkg::MAG_DIGITS;
   localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
   localparam int CELL_W = $clog2(NCELL + 1);
   localparam int BIT_W  = $clog2(ffd_pkg::MAG_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_ALIGN,
      ST_EMIT
   } state_type;

   state_type                       state_ff;
   logic [ffd_pkg::MAG_W-1:0]       mag_ff;
   logic                            neg_ff;
   logic                            err_ff;
   logic                            ovf_ff;
   logic                            point_ff;
   logic [BIT_W-1:0]                bit_cnt_ff;
   logic [CELL_W-1:0]               align_cnt_ff;
   logic [LEN_W-1:0]                pos_ff;
   logic [LEN_W-1:0]                ndig_ff;
   logic [LEN_W-1:0]                last_pos_ff;
   logic [1:0]                      limit_ff;
   logic                            blank_ff;
   logic                            rsp_valid_ff;
   ffd_pkg::rsp_type                rsp_ff;

   logic                            accept;
   logic [LEN_W-1:0]                len_sat;
   logic                            err_c;
   logic [LEN_W-1:0]                ndig_c;
   logic [1:0]                      limit_c;
   logic [LEN_W-1:0]                nd_c;

   ffd_pkg::cell_ctl_type           ctl;
   logic [ffd_pkg::DIGIT_W-1:0]     top_digit;
   logic [ffd_pkg::DIGIT_W-1:0]     next_digit;

   logic                            emit_fire;
   logic                            is_point;
   logic                            blank_here;
   logic                            next_blank;
   logic [LEN_W:0]                  pos_next;
   logic [ffd_pkg::CHAR_W-1:0]      char_c;
   logic [ffd_pkg::STATUS_W-1:0]    status_c;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Field setup from the incoming item
   always_comb begin
      if (32'(req_payload.field_length) > 32'(MAX_LENGTH)) begin
         len_sat = LEN_W'(MAX_LENGTH);
      end else begin
         len_sat = LEN_W'(req_payload.field_length);
      end
      err_c  = 32'(req_payload.decimal_places) >= 32'(len_sat);
      ndig_c = len_sat - LEN_W'(req_payload.decimal_places) - LEN_W'(1);
      nd_c   = len_sat - LEN_W'(1);
      if (32'(ndig_c) > 32'd4) begin
         limit_c = 2'd3;
      end else if (32'(ndig_c) > 32'd1) begin
         limit_c = 2'(ndig_c - LEN_W'(1));
      end else begin
         limit_c = 2'd0;
      end
   end

   // Digit chain control
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign is_point  = (pos_ff == ndig_ff);

   always_comb begin
      ctl.clear  = accept;
      ctl.dabble = (state_ff == ST_CONV);
      ctl.shift  = ((state_ff == ST_ALIGN) && (align_cnt_ff != '0)) ||
                   (emit_fire && !is_point && !err_ff);
   end

   ffd_chain #(
      .NCELL (NCELL)
   ) u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .mag_bit    (mag_ff[ffd_pkg::MAG_W-1]),
      .top_digit  (top_digit),
      .next_digit (next_digit)
   );

   // Character selection with leading-zero blanking and minus placement
   always_comb begin
      pos_next   = {1'b0, pos_ff} + (LEN_W+1)'(1);
      blank_here = blank_ff && ({1'b0, pos_ff} < (LEN_W+1)'(limit_ff)) &&
                   (top_digit == '0);
      next_blank = (pos_next < (LEN_W+1)'(limit_ff)) && (next_digit == '0);
      priority if (err_ff) begin
         char_c = ffd_pkg::CH_SPACE;
      end else if (is_point) begin
         char_c = point_ff ? ffd_pkg::CH_POINT : ffd_pkg::CH_SPACE;
      end else if (blank_here) begin
         char_c = (neg_ff && !next_blank) ? ffd_pkg::CH_MINUS : ffd_pkg::CH_SPACE;
      end else begin
         char_c = ffd_pkg::CH_ZERO + {4'b0000, top_digit};
      end
      priority if (err_ff) begin
         status_c = ffd_pkg::STATUS_LENGTH;
      end else if (ovf_ff) begin
         status_c = ffd_pkg::STATUS_RANGE;
      end else begin
         status_c = ffd_pkg::STATUS_OK;
      end
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_fire) begin
            rsp_ff.character <= char_c;
            rsp_ff.position  <= ffd_pkg::POS_W'(pos_ff);
            rsp_ff.last      <= (pos_ff == last_pos_ff);
            rsp_ff.status    <= status_c;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  mag_ff       <= req_payload.magnitude;
                  neg_ff       <= req_payload.negative;
                  err_ff       <= err_c;
                  ovf_ff       <= 1'b0;
                  point_ff     <= (req_payload.decimal_places != '0);
                  bit_cnt_ff   <= '0;
                  align_cnt_ff <= CELL_W'(NCELL) - CELL_W'(nd_c);
                  pos_ff       <= '0;
                  ndig_ff      <= ndig_c;
                  last_pos_ff  <= (len_sat == '0) ? '0 : nd_c;
                  limit_ff     <= limit_c;
                  blank_ff     <= 1'b1;
                  state_ff     <= err_c ? ST_EMIT : ST_CONV;
               end
            end
            ST_CONV: begin
               mag_ff     <= {mag_ff[ffd_pkg::MAG_W-2:0], 1'b0};
               bit_cnt_ff <= bit_cnt_ff + BIT_W'(1);
               if (bit_cnt_ff == BIT_W'(ffd_pkg::MAG_W - 1)) begin
                  state_ff <= ST_ALIGN;
               end
            end
            ST_ALIGN: begin
               // drop digits above the field; any nonzero one is an overflow
               if (align_cnt_ff == '0) begin
                  state_ff <= ST_EMIT;
               end else begin
                  ovf_ff       <= ovf_ff || (top_digit != '0);
                  align_cnt_ff <= align_cnt_ff - CELL_W'(1);
               end
            end
            ST_EMIT: begin
               if (emit_fire) begin
                  pos_ff <= pos_next[LEN_W-1:0];
                  if (!is_point) begin
                     blank_ff <= blank_here;
                  end
                  if (pos_ff == last_pos_ff) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- rtl/ffd_checker.sv -----
`timescale 1ns / 1ps

module ffd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ffd_pkg::rsp_type rsp_payload
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result item changed");

   // Every item yields at least one character, so the block is busy after taking one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after an item was taken");

   // Characters of one field follow back to back with rising position and same status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last |=>
         rsp_valid &&
         (rsp_payload.position == $past(rsp_payload.position) + 4'd1) &&
         (rsp_payload.status == $past(rsp_payload.status)))
      else $error("field characters out of sequence");

   // A field with too many decimal places is all spaces
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ffd_pkg::STATUS_LENGTH) |->
         (rsp_payload.character == ffd_pkg::CH_SPACE))
      else $error("length error field shows a non-space character");

endmodule

bind fixed_field_decimal_formatter_core ffd_checker u_ffd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ----- dv/fixed_field_decimal_formatter_core_test.sv -----
`timescale 1ns / 1ps

module fixed_field_decimal_formatter_core_test;

   localparam int FIELD_MAX   = ffd_pkg::MAX_LENGTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 120;
   localparam int PRINT_CAP   = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ffd_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ffd_pkg::rsp_type rsp_payload;

   fixed_field_decimal_formatter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   ffd_pkg::req_type pending_fields[$];
   ffd_pkg::rsp_type expected_chars[$];
   int               fields_queued = 0;
   int               fields_sent = 0;
   int               chars_checked = 0;
   int               overflow_fields = 0;
   int               bad_length_fields = 0;
   int               error_count = 0;
   int               cycle_count = 0;
   bit               idle_mode = 1'b1;
   int               req_gap = 0;
   int               rsp_hold = 0;
   ffd_pkg::rsp_type want;

   // One line per mismatch; the count keeps going once printing is capped
   task automatic flag_mismatch(input string msg);
      if (error_count < PRINT_CAP)
         $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Build the characters of one field and queue them
   task automatic format_field(input ffd_pkg::req_type r);
      logic [ffd_pkg::CHAR_W-1:0]   text [FIELD_MAX];
      logic [ffd_pkg::STATUS_W-1:0] st;
      longint unsigned              v;
      int                           len, prec, ndig, nchar, zeros, blank_max, k;
      ffd_pkg::rsp_type             c;
      len = int'(r.field_length);
      if (len > FIELD_MAX)
         len = FIELD_MAX;
      prec = int'(r.decimal_places);
      st = ffd_pkg::STATUS_OK;
      if (prec >= len) begin
         // length error: all spaces, at least one character
         st = ffd_pkg::STATUS_LENGTH;
         nchar = (len == 0) ? 1 : len;
         for (k = 0; k < nchar; k++)
            text[k] = ffd_pkg::CH_SPACE;
      end else begin
         ndig = len - prec - 1;
         nchar = len;
         v = 64'(r.magnitude);
         // digits from the right, point slot skipped
         for (k = len - 1; k >= 0; k--) begin
            if (k == ndig) begin
               text[k] = (prec > 0) ? ffd_pkg::CH_POINT : ffd_pkg::CH_SPACE;
            end else begin
               text[k] = ffd_pkg::CH_ZERO + ffd_pkg::CHAR_W'(v % 10);
               v = v / 10;
            end
         end
         if (v != 0)
            st = ffd_pkg::STATUS_RANGE;
         // blank up to three leading zeros, keep the units digit
         blank_max = (ndig > 1) ? ndig - 1 : 0;
         if (blank_max > 3)
            blank_max = 3;
         zeros = 0;
         while (zeros < blank_max && text[zeros] == ffd_pkg::CH_ZERO)
            zeros++;
         for (k = 0; k < zeros; k++)
            text[k] = ffd_pkg::CH_SPACE;
         if (zeros > 0 && r.negative)
            text[zeros - 1] = ffd_pkg::CH_MINUS;
      end
      if (st == ffd_pkg::STATUS_RANGE)
         overflow_fields++;
      if (st == ffd_pkg::STATUS_LENGTH)
         bad_length_fields++;
      for (k = 0; k < nchar; k++) begin
         c.character = text[k];
         c.position  = ffd_pkg::POS_W'(k);
         c.last      = (k == nchar - 1);
         c.status    = st;
         expected_chars.push_back(c);
      end
   endtask

   function automatic ffd_pkg::req_type make_item(input logic [ffd_pkg::MAG_W-1:0] mag,
                                                  input bit neg,
                                                  input int len, input int prec);
      ffd_pkg::req_type r;
      r.magnitude      = mag;
      r.negative       = neg;
      r.field_length   = ffd_pkg::FLEN_W'(len);
      r.decimal_places = ffd_pkg::PREC_W'(prec);
      return r;
   endfunction

   // Mostly well-formed fields with a chosen digit count; the rest fully random
   function automatic ffd_pkg::req_type random_item();
      ffd_pkg::req_type r;
      longint unsigned  span;
      int               digits, k;
      if ($urandom_range(0, 9) < 7) begin
         r.field_length   = ffd_pkg::FLEN_W'($urandom_range(1, FIELD_MAX));
         r.decimal_places = ffd_pkg::PREC_W'($urandom_range(0, r.field_length - 1));
         digits = $urandom_range(0, 10);
         span = 1;
         for (k = 0; k < digits; k++)
            span = span * 10;
         r.magnitude = ffd_pkg::MAG_W'({$urandom, $urandom} % span);
         r.negative  = 1'($urandom_range(0, 1));
      end else begin
         r.magnitude      = $urandom;
         r.negative       = 1'($urandom_range(0, 1));
         r.field_length   = ffd_pkg::FLEN_W'($urandom);
         r.decimal_places = ffd_pkg::PREC_W'($urandom);
      end
      return r;
   endfunction

   // Input driver: accepts on valid and not stall, then presents the next item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            format_field(req_payload);
            fields_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (idle_mode && $urandom_range(0, 3) == 0) begin
               req_gap = $urandom_range(1, 15) - 1;
               req_valid <= 1'b0;
            end else if (pending_fields.size() > 0) begin
               req_valid <= 1'b1;
               req_payload <= pending_fields.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Output monitor: checks each accepted character, drives stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
               flag_mismatch($sformatf("character 0x%0h at position %0d with nothing expected",
                                       rsp_payload.character, rsp_payload.position));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_payload.character !== want.character)
                  flag_mismatch($sformatf("character 0x%0h, expected 0x%0h at position %0d",
                                          rsp_payload.character, want.character,
                                          want.position));
               if (rsp_payload.position !== want.position)
                  flag_mismatch($sformatf("position %0d, expected %0d",
                                          rsp_payload.position, want.position));
               if (rsp_payload.last !== want.last)
                  flag_mismatch($sformatf("last %0b, expected %0b at position %0d",
                                          rsp_payload.last, want.last, want.position));
               if (rsp_payload.status !== want.status)
                  flag_mismatch($sformatf("status %0d, expected %0d at position %0d",
                                          rsp_payload.status, want.status, want.position));
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if (idle_mode && $urandom_range(0, 7) == 0) begin
            rsp_hold = $urandom_range(1, 15) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters still expected",
                  cycle_count, expected_chars.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic queue_item(input ffd_pkg::req_type r);
      pending_fields.push_back(r);
      fields_queued++;
   endtask

   task automatic run_random(input int count, input bit with_idle);
      int n;
      idle_mode = with_idle;
      for (n = 0; n < count; n++)
         queue_item(random_item());
      while (fields_sent != fields_queued)
         @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, blanking with and without a minus, errors
      queue_item(make_item(32'd0, 1'b0, 16, 0));
      queue_item(make_item(32'd0, 1'b1, 8, 2));
      queue_item(make_item(32'hFFFF_FFFF, 1'b0, 16, 0));
      queue_item(make_item(32'hFFFF_FFFF, 1'b1, 16, 9));
      queue_item(make_item(32'hFFFF_FFFF, 1'b0, 16, 15));
      queue_item(make_item(32'd123456, 1'b1, 4, 1));
      queue_item(make_item(32'd0, 1'b0, 0, 0));
      queue_item(make_item(32'd17, 1'b1, 5, 5));
      queue_item(make_item(32'd17, 1'b0, 3, 15));
      queue_item(make_item(32'd12345, 1'b1, 31, 2));
      queue_item(make_item(32'd98765, 1'b0, 17, 0));
      queue_item(make_item(32'd999, 1'b1, 4, 0));
      queue_item(make_item(32'd5, 1'b1, 3, 1));
      queue_item(make_item(32'd7, 1'b0, 1, 0));
      queue_item(make_item(32'd5, 1'b1, 2, 0));
      queue_item(make_item(32'd42, 1'b1, 10, 3));
      queue_item(make_item(32'd1000, 1'b1, 9, 0));
      queue_item(make_item(32'd1, 1'b1, 16, 14));
      queue_item(make_item(32'h8000_0000, 1'b0, 12, 1));
      queue_item(make_item(32'h5555_5555, 1'b1, 16, 10));
      queue_item(make_item(32'd10, 1'b0, 16, 1));
      queue_item(make_item(32'd0, 1'b1, 1, 0));
      while (fields_sent != fields_queued)
         @(posedge clock);

      // random: idle bursts, a quiet stretch, idle again, quiet tail
      run_random(70, 1'b1);
      run_random(35, 1'b0);
      run_random(60, 1'b1);
      run_random(35, 1'b0);

      while (expected_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d fields and checked %0d characters", fields_sent, chars_checked);
      $display("%0d fields overflowed, %0d had too many decimal places",
               overflow_fields, bad_length_fields);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- fixed_field_decimal_formatter_core.f -----
rtl/ffd_pkg.sv
rtl/ffd_cell.sv
rtl/ffd_chain.sv
rtl/fixed_field_decimal_formatter_core.sv
rtl/ffd_checker.sv
dv/fixed_field_decimal_formatter_core_test.sv
